// ===== rtl/core/bba_pkg.sv =====
// bba_pkg: shared types, codes and constants of the buddy block allocator
// no dependencies
`default_nettype none
package bba_pkg;

   localparam int DEF_REGION_LOG2    = 20;
   localparam int DEF_MIN_BLOCK_LOG2 = 5;
   localparam logic [31:0] BASE_RESET = 32'h00F0_0000;
   localparam int SIZE_W  = 24;
   localparam int ADDR_W  = 32;
   localparam int TOTAL_W = 21;
   localparam int LOG_W   = 5;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL   = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [1:0] NODE_FREE  = 2'd0;
   localparam logic [1:0] NODE_ALLOC = 2'd1;
   localparam logic [1:0] NODE_PART  = 2'd2;
   localparam logic [1:0] NODE_FULL  = 2'd3;

   typedef struct packed {
      logic              func;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } bba_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ADDR_W-1:0]  granted_address;
      logic [TOTAL_W-1:0] allocated_bytes;
   } bba_rsp_type;

   function automatic logic node_is_full(input logic [1:0] s);
      return (s == NODE_ALLOC) || (s == NODE_FULL);
   endfunction

   function automatic logic [1:0] merge_state(input logic [1:0] l, input logic [1:0] r);
      if (node_is_full(l) && node_is_full(r)) return NODE_FULL;
      else if (l == NODE_FREE && r == NODE_FREE) return NODE_FREE;
      else return NODE_PART;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bba_tree_mem.sv =====
// bba_tree_mem: node state memory, one write and one read port, registered read
// root node held in a flip-flop so it resets to free; uses bba_pkg
`default_nettype none
module bba_tree_mem #(
   parameter int IW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [IW-1:0] rd_idx,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_idx,
   input  wire logic [1:0]    wr_state,
   output      logic [1:0]    rd_state
);
   import bba_pkg::*;

   localparam int DEPTH = 1 << IW;

   logic [1:0] mem [DEPTH];
   logic [1:0] rdata_ff;
   logic       sel_root_ff;
   logic [1:0] root_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_idx != '0) begin
         mem[wr_idx] <= wr_state;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_idx];
         sel_root_ff <= (rd_idx == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= NODE_FREE;
      end else if (wr_en && wr_idx == '0) begin
         root_ff <= wr_state;
      end
   end

   assign rd_state = sel_root_ff ? root_ff : rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// bba_ctrl: tree walk sequencer for allocate and free, with upward merge pass
// uses bba_pkg, instantiates bba_tree_mem
`default_nettype none
module bba_ctrl #(
   parameter int REGION_LOG2    = bba_pkg::DEF_REGION_LOG2,
   parameter int MIN_BLOCK_LOG2 = bba_pkg::DEF_MIN_BLOCK_LOG2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         go,
   input  wire logic                         func,
   input  wire logic                         legal,
   input  wire logic [bba_pkg::LOG_W-1:0]    blog,
   input  wire logic [bba_pkg::ADDR_W-1:0]   addr,
   input  wire logic [bba_pkg::ADDR_W-1:0]   base,
   output      logic                         busy,
   output      logic                         done,
   output      logic                         done_alloc,
   output      logic [1:0]                   done_status,
   output      logic [REGION_LOG2-1:0]       done_offset,
   output      logic [bba_pkg::TOTAL_W-1:0]  total
);
   import bba_pkg::*;

   localparam int TL = (REGION_LOG2 > MIN_BLOCK_LOG2) ? (REGION_LOG2 - MIN_BLOCK_LOG2) : 0;
   localparam int IW = TL + 1;
   localparam int LW = (TL > 0) ? $clog2(TL + 1) : 1;
   localparam int RW = REGION_LOG2;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_A_RD  = 9'b000000010,
      S_A_EV  = 9'b000000100,
      S_BACK  = 9'b000001000,
      S_SPLIT = 9'b000010000,
      S_F_RD  = 9'b000100000,
      S_F_EV  = 9'b001000000,
      S_U_RD  = 9'b010000000,
      S_U_EV  = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic [RW-1:0]      off_ff, off_in;
   logic [1:0]         cs_ff, cs_in;
   logic               func_ff, func_in;
   logic [LOG_W-1:0]   blog_ff, blog_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               done_ff, done_in;
   logic [1:0]         status_ff, status_in;

   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_idx, wr_idx;
   logic [1:0]         wr_state, rd_state;

   logic [LOG_W-1:0]   nlog;
   logic [RW:0]        node_size, half_size;
   logic [ADDR_W-1:0]  node_addr, split_addr;
   logic               has_kids;
   logic [IW-1:0]      left_idx, right_idx, parent_idx, sib_idx;
   logic [1:0]         lst, rst;

   assign nlog       = LOG_W'(REGION_LOG2) - LOG_W'(lvl_ff);
   assign node_size  = (RW+1)'(1) << nlog;
   assign half_size  = node_size >> 1;
   assign node_addr  = base + ADDR_W'(off_ff);
   assign split_addr = node_addr + ADDR_W'(half_size);
   assign has_kids   = (32'(lvl_ff) < TL);
   assign left_idx   = (idx_ff << 1) + IW'(1);
   assign right_idx  = (idx_ff << 1) + IW'(2);
   assign parent_idx = (idx_ff - IW'(1)) >> 1;
   assign sib_idx    = idx_ff[0] ? idx_ff + IW'(1) : idx_ff - IW'(1);
   assign lst        = idx_ff[0] ? cs_ff : rd_state;
   assign rst        = idx_ff[0] ? rd_state : cs_ff;

   bba_tree_mem #(.IW(IW)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_state (wr_state),
      .rd_state (rd_state)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      lvl_in    = lvl_ff;
      off_in    = off_ff;
      cs_in     = cs_ff;
      func_in   = func_ff;
      blog_in   = blog_ff;
      addr_in   = addr_ff;
      total_in  = total_ff;
      status_in = status_ff;
      done_in   = 1'b0;
      rd_en     = 1'b0;
      rd_idx    = idx_ff;
      wr_en     = 1'b0;
      wr_idx    = idx_ff;
      wr_state  = cs_ff;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               func_in = func;
               blog_in = blog;
               addr_in = addr;
               idx_in  = '0;
               lvl_in  = '0;
               off_in  = '0;
               if (func == FUNC_FREE) begin
                  state_in = S_F_RD;
               end else if (!legal) begin
                  status_in = STATUS_ILLEGAL;
                  done_in   = 1'b1;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end
         S_A_RD: begin
            rd_en    = 1'b1;
            state_in = S_A_EV;
         end
         S_A_EV: begin
            case (rd_state)
               NODE_PART: begin
                  if (has_kids) begin
                     idx_in   = left_idx;
                     lvl_in   = lvl_ff + LW'(1);
                     state_in = S_A_RD;
                  end else begin
                     state_in = S_BACK;
                  end
               end
               NODE_FREE: begin
                  if (blog_ff > nlog) begin
                     state_in = S_BACK;
                  end else if (blog_ff == nlog) begin
                     cs_in     = NODE_ALLOC;
                     total_in  = total_ff + TOTAL_W'(node_size);
                     status_in = STATUS_OK;
                     state_in  = S_U_RD;
                  end else begin
                     state_in = S_SPLIT;
                  end
               end
               default: begin
                  state_in = S_BACK;
               end
            endcase
         end
         S_BACK: begin
            if (idx_ff == '0) begin
               status_in = STATUS_NO_SPACE;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else if (idx_ff[0]) begin
               idx_in   = idx_ff + IW'(1);
               off_in   = off_ff + RW'(node_size);
               state_in = S_A_RD;
            end else begin
               idx_in = parent_idx;
               off_in = off_ff - RW'(node_size);
               lvl_in = lvl_ff - LW'(1);
            end
         end
         S_SPLIT: begin
            if (blog_ff == nlog) begin
               cs_in     = NODE_ALLOC;
               total_in  = total_ff + TOTAL_W'(node_size);
               status_in = STATUS_OK;
               state_in  = S_U_RD;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = right_idx;
               wr_state = NODE_FREE;
               idx_in   = left_idx;
               lvl_in   = lvl_ff + LW'(1);
            end
         end
         S_F_RD: begin
            rd_en    = 1'b1;
            state_in = S_F_EV;
         end
         S_F_EV: begin
            if ((rd_state == NODE_PART || rd_state == NODE_FULL) && has_kids) begin
               lvl_in   = lvl_ff + LW'(1);
               state_in = S_F_RD;
               if (split_addr > addr_ff) begin
                  idx_in = left_idx;
               end else begin
                  idx_in = right_idx;
                  off_in = off_ff + RW'(half_size);
               end
            end else if (rd_state == NODE_ALLOC && node_addr == addr_ff) begin
               cs_in     = NODE_FREE;
               total_in  = total_ff - TOTAL_W'(node_size);
               status_in = STATUS_OK;
               state_in  = S_U_RD;
            end else begin
               status_in = STATUS_NOT_FOUND;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_U_RD: begin
            wr_en = 1'b1;
            if (idx_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = sib_idx;
               state_in = S_U_EV;
            end
         end
         S_U_EV: begin
            cs_in    = merge_state(lst, rst);
            idx_in   = parent_idx;
            lvl_in   = lvl_ff - LW'(1);
            state_in = S_U_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lvl_ff    <= lvl_in;
      off_ff    <= off_in;
      cs_ff     <= cs_in;
      func_ff   <= func_in;
      blog_ff   <= blog_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign done        = done_ff;
   assign done_alloc  = (func_ff == FUNC_ALLOC);
   assign done_status = status_ff;
   assign done_offset = off_ff;
   assign total       = total_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == S_IDLE)
      else $error("result strobe outside idle");
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && go) |=> (state_ff != S_IDLE || done_ff))
      else $error("accepted transaction dropped");
   a_root_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && idx_ff == '0) |-> lvl_ff == '0)
      else $error("root index off level zero");
   a_no_total_on_miss: assert property (@(posedge clock) disable iff (reset)
      (done_ff && status_ff != STATUS_OK) |-> $stable(total_ff))
      else $error("total changed on failed transaction");

endmodule
`default_nettype wire

// ===== rtl/core/buddy_block_allocator_core.sv =====
// channel   ports                                  handshake
// req       start, busy, req_data                  taken when start && !busy
// rsp       rsp_strobe, rsp_data                   one cycle, no back pressure
// csr       csr_write_enable, csr_write_data       written when enable is high
//
// an allocate reads each node of its depth-first search in a read and an evaluate
// state, goes to the right sibling or up a level per back step, splits a level
// per split step, then walks to the root with a read and a merge state per level
// and writes the root; a free reads down level by level and walks up the same way.
// the node memory read is registered, hence the evaluate states. the strobe comes
// in the cycle after the last step, so an illegal size answers in the cycle after
// it is taken. reset is synchronous; the root resets to free, the total to zero.
// results cannot be stalled; a new transaction may start while a result shows.
// depends on bba_pkg, bba_ctrl, bba_tree_mem
`default_nettype none
module buddy_block_allocator_core #(
   parameter int REGION_LOG2    = bba_pkg::DEF_REGION_LOG2,
   parameter int MIN_BLOCK_LOG2 = bba_pkg::DEF_MIN_BLOCK_LOG2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire bba_pkg::bba_req_type        req_data,
   output      logic                        rsp_strobe,
   output      bba_pkg::bba_rsp_type        rsp_data,
   input  wire logic                        csr_write_enable,
   input  wire logic [bba_pkg::ADDR_W-1:0]  csr_write_data
);
   import bba_pkg::*;

   logic [ADDR_W-1:0]      base_ff;
   logic [SIZE_W-1:0]      size_m1;
   logic [LOG_W-1:0]       ceil_log, blog;
   logic                   legal;
   logic                   done, done_alloc;
   logic [1:0]             done_status;
   logic [REGION_LOG2-1:0] done_offset;
   logic [TOTAL_W-1:0]     total;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   assign size_m1 = req_data.request_size - SIZE_W'(1);

   always_comb begin
      ceil_log = '0;
      for (int b = 0; b < SIZE_W; b++) begin
         if (size_m1[b]) ceil_log = LOG_W'(b + 1);
      end
      if (req_data.request_size <= SIZE_W'(1)) ceil_log = '0;
      blog = (ceil_log < LOG_W'(MIN_BLOCK_LOG2)) ? LOG_W'(MIN_BLOCK_LOG2) : ceil_log;
   end

   assign legal = (req_data.request_size != '0) &&
                  ({1'b0, req_data.request_size} <= ((SIZE_W+1)'(1) << REGION_LOG2));

   bba_ctrl #(
      .REGION_LOG2    (REGION_LOG2),
      .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .go          (start),
      .func        (req_data.func),
      .legal       (legal),
      .blog        (blog),
      .addr        (req_data.block_address),
      .base        (base_ff),
      .busy        (busy),
      .done        (done),
      .done_alloc  (done_alloc),
      .done_status (done_status),
      .done_offset (done_offset),
      .total       (total)
   );

   assign rsp_strobe                = done;
   assign rsp_data.status           = done_status;
   assign rsp_data.granted_address  = (done_alloc && done_status == STATUS_OK) ?
                                      base_ff + ADDR_W'(done_offset) : '0;
   assign rsp_data.allocated_bytes  = total;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for buddy_block_allocator_core: directed and random allocate/free traffic
// checked against a behavioral buddy tree predictor; depends on bba_pkg and the rtl
`default_nettype none
module testbench;
   import bba_pkg::*;

   localparam int REGION   = DEF_REGION_LOG2;
   localparam int MIN_LOG  = DEF_MIN_BLOCK_LOG2;
   localparam int LEVELS   = (REGION > MIN_LOG) ? (REGION - MIN_LOG) : 0;
   localparam int NODES    = 1 << (LEVELS + 1);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   bba_req_type req_data = '0;
   logic        rsp_strobe;
   bba_rsp_type rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [ADDR_W-1:0] csr_write_data = '0;

   buddy_block_allocator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [1:0]  tree_state [NODES];
   logic [31:0] held_bytes;
   logic [31:0] region_base;
   bba_rsp_type pending_results [$];
   logic [31:0] live_blocks [$];
   int          error_count = 0;
   bit          steady_stretch = 1'b0;

   function automatic bit has_kids(int unsigned lvl);
      return lvl < LEVELS;
   endfunction

   function automatic void refresh(int unsigned i);
      tree_state[i] = merge_of(tree_state[2*i+1], tree_state[2*i+2]);
   endfunction

   function automatic logic [1:0] merge_of(logic [1:0] l, logic [1:0] r);
      bit lf = (l == NODE_ALLOC) || (l == NODE_FULL);
      bit rf = (r == NODE_ALLOC) || (r == NODE_FULL);
      if (lf && rf) return NODE_FULL;
      if (l == NODE_FREE && r == NODE_FREE) return NODE_FREE;
      return NODE_PART;
   endfunction

   function automatic bit carve(int unsigned i, int unsigned lvl, logic [31:0] off,
                                int unsigned blog, output logic [31:0] found);
      int unsigned nlog = REGION - lvl;
      logic [31:0] half;
      bit ok;
      logic [1:0] s = tree_state[i];
      found = '0;
      if (s == NODE_ALLOC || s == NODE_FULL) return 1'b0;
      if (s == NODE_PART) begin
         if (!has_kids(lvl)) return 1'b0;
         half = 32'd1 << (nlog - 1);
         ok = carve(2*i+1, lvl+1, off, blog, found);
         if (!ok) ok = carve(2*i+2, lvl+1, off + half, blog, found);
         refresh(i);
         return ok;
      end
      if (blog > nlog) return 1'b0;
      if (blog < nlog) begin
         if (!has_kids(lvl)) return 1'b0;
         tree_state[2*i+1] = NODE_FREE;
         tree_state[2*i+2] = NODE_FREE;
         ok = carve(2*i+1, lvl+1, off, blog, found);
         refresh(i);
         return ok;
      end
      tree_state[i] = NODE_ALLOC;
      held_bytes += 32'd1 << blog;
      found = off;
      return 1'b1;
   endfunction

   function automatic logic [1:0] release_at(int unsigned i, int unsigned lvl,
                                             logic [31:0] off, logic [31:0] addr);
      int unsigned nlog = REGION - lvl;
      logic [31:0] half;
      logic [1:0] ret;
      logic [1:0] s = tree_state[i];
      if ((s == NODE_PART || s == NODE_FULL) && has_kids(lvl)) begin
         half = 32'd1 << (nlog - 1);
         if (region_base + off + half > addr) ret = release_at(2*i+1, lvl+1, off, addr);
         else ret = release_at(2*i+2, lvl+1, off + half, addr);
         refresh(i);
         return ret;
      end
      if (s == NODE_ALLOC && region_base + off == addr) begin
         tree_state[i] = NODE_FREE;
         held_bytes -= 32'd1 << nlog;
         return STATUS_OK;
      end
      return STATUS_NOT_FOUND;
   endfunction

   function automatic bba_rsp_type predict_allocator(bba_req_type rq);
      bba_rsp_type r = '0;
      logic [31:0] size = {8'd0, rq.request_size};
      logic [31:0] off;
      int unsigned blog = 0;
      if (rq.func == FUNC_ALLOC) begin
         if (size == 0 || size > (32'd1 << REGION)) r.status = STATUS_ILLEGAL;
         else begin
            if (size < (32'd1 << MIN_LOG)) size = 32'd1 << MIN_LOG;
            while ((32'd1 << blog) < size) blog++;
            if (carve(0, 0, 32'd0, blog, off)) r.granted_address = region_base + off;
            else r.status = STATUS_NO_SPACE;
         end
      end else begin
         r.status = release_at(0, 0, 32'd0, rq.block_address);
      end
      r.allocated_bytes = held_bytes[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      bba_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", {30'd0, rsp_data.status}, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", {30'd0, rsp_data.status}, {30'd0, want.status});
            if (rsp_data.granted_address !== want.granted_address)
               report_mismatch("granted_address", rsp_data.granted_address,
                               want.granted_address);
            if (rsp_data.allocated_bytes !== want.allocated_bytes)
               report_mismatch("allocated_bytes", {11'd0, rsp_data.allocated_bytes},
                               {11'd0, want.allocated_bytes});
         end
      end
   end

   task automatic send_request(logic fn, logic [SIZE_W-1:0] size, logic [31:0] addr);
      bba_req_type rq;
      bba_rsp_type r;
      rq.func = fn;
      rq.request_size = size;
      rq.block_address = addr;
      @(negedge clock);
      req_data = rq;
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      r = predict_allocator(rq);
      pending_results.push_back(r);
      if (fn == FUNC_ALLOC && r.status == STATUS_OK) live_blocks.push_back(r.granted_address);
      if (!steady_stretch && $urandom_range(99) < 16) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
   endtask

   task automatic alloc(logic [SIZE_W-1:0] size);
      send_request(FUNC_ALLOC, size, $urandom);
   endtask

   task automatic free_block(logic [31:0] addr);
      send_request(FUNC_FREE, SIZE_W'($urandom), addr);
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      region_base = value;
   endtask

   task automatic free_all;
      while (live_blocks.size() != 0) free_block(live_blocks.pop_front());
   endtask

   task automatic test_sizes;
      alloc(24'd0);
      alloc(24'hFF_FFFF);
      alloc(24'h10_0001);
      alloc(24'd1);
      alloc(24'd32);
      alloc(24'd33);
      alloc(24'd4096);
      free_all();
      alloc(24'h10_0000);
      alloc(24'd1);
      free_all();
   endtask

   task automatic test_free_cases;
      logic [31:0] a;
      free_block(region_base);
      alloc(24'd64);
      a = live_blocks[0];
      free_block(a + 32);
      free_block(a + 64);
      free_block(32'hFFFF_FFFF);
      free_block(32'd0);
      free_block(a);
      void'(live_blocks.pop_front());
      free_block(a);
      alloc(24'd128);
      alloc(24'd128);
      alloc(24'd256);
      free_all();
   endtask

   task automatic test_address_wrap;
      write_base(32'hFFFF_F000);
      alloc(24'd2048);
      alloc(24'd2048);
      alloc(24'd8192);
      free_all();
      write_base(32'h0000_0000);
      alloc(24'd32);
      free_all();
   endtask

   task automatic random_phase(int count);
      int unsigned r, lg, k;
      logic [31:0] a;
      for (int n = 0; n < count; n++) begin
         if (n == count / 3) steady_stretch = 1'b1;
         if (n == count / 2) steady_stretch = 1'b0;
         r = $urandom_range(99);
         if (r < 8) begin
            if ($urandom_range(1))
               alloc($urandom_range(1) ? 24'd0
                                       : SIZE_W'($urandom_range(24'hFF_FFFF, 24'h10_0001)));
            else free_block($urandom);
         end else if (r < 12 && live_blocks.size() != 0) begin
            free_block(live_blocks[$urandom_range(live_blocks.size() - 1)]
                       + $urandom_range(1, 31));
         end else if (r < 55 || live_blocks.size() == 0) begin
            lg = ($urandom_range(99) < 80) ? $urandom_range(REGION, 12)
                                           : $urandom_range(11, MIN_LOG);
            if (lg == MIN_LOG) alloc(SIZE_W'($urandom_range(32'd1 << lg, 1)));
            else alloc(SIZE_W'($urandom_range(32'd1 << lg, (32'd1 << (lg - 1)) + 1)));
         end else begin
            k = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            free_block(a);
         end
         if (n == count / 4) drain();
      end
      free_all();
   endtask

   task automatic test_random;
      random_phase(250);
      write_base(32'hFFFF_FFFF);
      random_phase(150);
      write_base($urandom);
      random_phase(200);
      write_base(BASE_RESET);
      random_phase(170);
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) tree_state[i] = NODE_FREE;
      held_bytes = '0;
      region_base = BASE_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_sizes();
      test_free_cases();
      test_address_wrap();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("buddy_block_allocator_core regression: pass");
      else $display("buddy_block_allocator_core regression: fail");
      $finish;
   end

   initial begin
      #2_000_000_000;
      $display("buddy_block_allocator_core regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
